// ===== hw/rtl/three_point_frame_from_plane_unit_assert.svh =====
// Assertion macros shared by the frame unit modules.
`ifndef THREE_POINT_FRAME_FROM_PLANE_UNIT_ASSERT_SVH
`define THREE_POINT_FRAME_FROM_PLANE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define TPF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame unit check failed");
// Next-cycle implication.
`define TPF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame unit check failed");
`else
`define TPF_ASSERT_IMP(label, clk, rst, ante, cons)
`define TPF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/tpf_pkg.sv =====
// Shared constants, types and helper functions of the frame unit.
package tpf_pkg;

   localparam int COORD_BITS     = 24;
   localparam int AXIS_FRAC_BITS = 14;
   localparam int OUT_BITS       = 24;

   // difference and cross product operand widths
   localparam int CROSS_SHIFT = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int XOP_BITS    = DIFF_BITS - CROSS_SHIFT;
   localparam int AXIS_BITS   = AXIS_FRAC_BITS + 2;
   localparam int MUL_BITS    = (XOP_BITS > AXIS_BITS) ? XOP_BITS : AXIS_BITS;
   localparam int ACC_BITS    = 2 * MUL_BITS + 1;

   // normalizer widths
   localparam int SHIFT_HI  = 30;
   localparam int SHIFT_LO  = 29;
   localparam int NORM_BITS = (ACC_BITS > SHIFT_LO + 18) ? ACC_BITS : SHIFT_LO + 18;
   localparam int U_BITS    = SHIFT_HI;
   localparam int SQ_BITS   = 2 * U_BITS + 2;
   localparam int ROOT_BITS = SQ_BITS + 1;
   localparam int ROOT_STEPS = ROOT_BITS / 2 + 1;
   localparam int N_BITS    = U_BITS + 1;
   localparam int QUO_BITS  = AXIS_FRAC_BITS + 2;
   localparam int NUM_BITS  = U_BITS + AXIS_FRAC_BITS + 1;
   localparam int CNT_BITS  = 5;

   // decoupling queue
   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = 1;
   localparam int QCNT_BITS = 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [XOP_BITS-1:0]   xop_type;
   typedef logic signed [AXIS_BITS-1:0]  axis_type;
   typedef logic signed [OUT_BITS-1:0]   out_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Z = 2'd1,
      AXIS_Y = 2'd2,
      AXIS_T = 2'd3
   } axis_sel_type;

   localparam axis_type AXIS_MAX = {1'b0, {(AXIS_BITS-1){1'b1}}};
   localparam axis_type AXIS_MIN = {1'b1, {(AXIS_BITS-1){1'b0}}};

   // one queued item: X difference, cross operand, translation
   typedef struct packed {
      diff_type a0, a1, a2;
      xop_type  b0, b1, b2;
      out_type  t0, t1, t2;
   } item_type;

   typedef struct packed {
      logic done;
      logic ok;
   } norm_stat_type;

   // shift magnitude right for the cross product, sign kept
   function automatic xop_type shr_mag(input diff_type v);
      logic [DIFF_BITS-1:0] m;
      logic [XOP_BITS-1:0]  r;
      m = v[DIFF_BITS-1] ? (~v + 1'b1) : v;
      m = m >> CROSS_SHIFT;
      r = m[XOP_BITS-1:0];
      return v[DIFF_BITS-1] ? xop_type'(~r + 1'b1) : xop_type'(r);
   endfunction

   // signed axis value from a magnitude, saturated to Q1.F range
   function automatic axis_type axis_from_mag(input logic over,
                                              input logic [AXIS_BITS-1:0] m,
                                              input logic neg);
      if (over)
         return neg ? AXIS_MIN : AXIS_MAX;
      return neg ? axis_type'(~m + 1'b1) : axis_type'(m);
   endfunction

endpackage

// ===== hw/rtl/three_point_frame_from_plane_unit.sv =====
// Top level of the three-point frame unit.
//
// Input queue: drive the nine point coordinates (origin, point on the X axis,
// point in the plane) with req_push; the item is taken on a clock edge where
// req_push is high and req_full is low. Two items can wait in the input queue.
// Result queue: while rsp_empty is low the current result is on the rsp_
// ports; rsp_pop takes it. Each item gives four results in the order X axis,
// Z axis, Y axis, translation; rsp_last marks the translation, rsp_degenerate
// flags a zero norm (axes then read zero).
// Timing from acceptance to the first result depends on the normalizer shift
// steps; a zero X difference or a collinear point set gives its results sooner.
// The back end works on one item at a time and takes the next item from the
// queue only after the last result of the current item is popped. An item that
// is not degenerate goes through a 32-step square root and three divisions in
// the normalizer, once for X and once for Z, plus two cross product passes.
// A stalled receiver holds the results; the input queue keeps accepting until
// it is full.
// Reset (synchronous, active high) empties the queue and aborts any item.
module three_point_frame_from_plane_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  tpf_pkg::coord_type req_origin_x,
   input  tpf_pkg::coord_type req_origin_y,
   input  tpf_pkg::coord_type req_origin_z,
   input  tpf_pkg::coord_type req_xpoint_x,
   input  tpf_pkg::coord_type req_xpoint_y,
   input  tpf_pkg::coord_type req_xpoint_z,
   input  tpf_pkg::coord_type req_plane_x,
   input  tpf_pkg::coord_type req_plane_y,
   input  tpf_pkg::coord_type req_plane_z,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_axis_sel,
   output tpf_pkg::out_type   rsp_comp_x,
   output tpf_pkg::out_type   rsp_comp_y,
   output tpf_pkg::out_type   rsp_comp_z,
   output logic               rsp_degenerate,
   output logic               rsp_last
);
   import tpf_pkg::*;

   logic     q_valid, q_pop;
   item_type q_item;

   // front end and queue
   tpf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_origin_z (req_origin_z),
      .req_xpoint_x (req_xpoint_x),
      .req_xpoint_y (req_xpoint_y),
      .req_xpoint_z (req_xpoint_z),
      .req_plane_x  (req_plane_x),
      .req_plane_y  (req_plane_y),
      .req_plane_z  (req_plane_z),
      .deq_valid    (q_valid),
      .deq_pop      (q_pop),
      .deq_item     (q_item)
   );

   // back end
   tpf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_item         (q_item),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_axis_sel   (rsp_axis_sel),
      .rsp_comp_x     (rsp_comp_x),
      .rsp_comp_y     (rsp_comp_y),
      .rsp_comp_z     (rsp_comp_z),
      .rsp_degenerate (rsp_degenerate),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== hw/rtl/tpf_norm.sv =====
// Iterative vector normalizer: shift, sum of squares, square root, divide.
module tpf_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tpf_pkg::acc_type      vec [3],
   output tpf_pkg::axis_type     unit [3],
   output tpf_pkg::norm_stat_type stat
);
   import tpf_pkg::*;

   typedef enum logic [6:0] {
      N_IDLE  = 7'b0000001,
      N_SHIFT = 7'b0000010,
      N_SQ    = 7'b0000100,
      N_ROOT  = 7'b0001000,
      N_DLOAD = 7'b0010000,
      N_DRUN  = 7'b0100000,
      N_DONE  = 7'b1000000
   } norm_state_type;

   localparam logic [NORM_BITS-1:0] HI_LIM = NORM_BITS'(1) << SHIFT_HI;
   localparam logic [NORM_BITS-1:0] LO_LIM = NORM_BITS'(1) << SHIFT_LO;
   localparam logic [NORM_BITS-1:0] R16 = NORM_BITS'(1) << (SHIFT_LO + 16);
   localparam logic [NORM_BITS-1:0] R8  = NORM_BITS'(1) << (SHIFT_LO + 8);
   localparam logic [NORM_BITS-1:0] R4  = NORM_BITS'(1) << (SHIFT_LO + 4);
   localparam logic [NORM_BITS-1:0] R2  = NORM_BITS'(1) << (SHIFT_LO + 2);
   localparam logic [NORM_BITS-1:0] L16 = NORM_BITS'(1) << (SHIFT_HI - 16);
   localparam logic [NORM_BITS-1:0] L8  = NORM_BITS'(1) << (SHIFT_HI - 8);
   localparam logic [NORM_BITS-1:0] L4  = NORM_BITS'(1) << (SHIFT_HI - 4);
   localparam logic [NORM_BITS-1:0] L2  = NORM_BITS'(1) << (SHIFT_HI - 2);
   localparam int SQ_LAST = 3;

   norm_state_type state_ff, state_in;
   logic [NORM_BITS-1:0] u_ff [3], u_in [3];
   logic [NORM_BITS-1:0] m_ff, m_in;
   logic                 neg_ff [3], neg_in [3];
   logic [2*U_BITS-1:0]  prod_ff, prod_in;
   logic [SQ_BITS-1:0]   q_ff, q_in, srem_ff, srem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in, bit_ff, bit_in;
   logic [N_BITS-1:0]    n_ff, n_in, drem_ff, drem_in;
   logic [QUO_BITS-1:0]  num_ff, num_in, quo_ff, quo_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [1:0]           k_ff, k_in;
   axis_type             unit_ff [3], unit_in [3];
   logic                 ok_ff, ok_in;

   logic [ACC_BITS-1:0]  mag_acc [3];
   logic [NORM_BITS-1:0] mag_v [3];
   logic [NORM_BITS-1:0] m_start;
   logic [4:0]           rs, ls;
   logic [U_BITS-1:0]    sq_u;
   logic [ROOT_BITS-1:0] rt_sum;
   logic                 rt_ge;
   logic [NUM_BITS-1:0]  num_full;
   logic [N_BITS:0]      dv_t;
   logic                 dv_ge;

   // magnitudes and largest magnitude of the incoming vector
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_acc[i] = vec[i][ACC_BITS-1] ? (~vec[i] + 1'b1) : vec[i];
         mag_v[i]   = NORM_BITS'(mag_acc[i]);
      end
      m_start = mag_v[0];
      if (mag_v[1] > m_start) m_start = mag_v[1];
      if (mag_v[2] > m_start) m_start = mag_v[2];
   end

   // shift step sizes toward [2^29, 2^30)
   always_comb begin
      if (m_ff >= R16)      rs = 5'd16;
      else if (m_ff >= R8)  rs = 5'd8;
      else if (m_ff >= R4)  rs = 5'd4;
      else if (m_ff >= R2)  rs = 5'd2;
      else                  rs = 5'd1;
      if (m_ff < L16)       ls = 5'd16;
      else if (m_ff < L8)   ls = 5'd8;
      else if (m_ff < L4)   ls = 5'd4;
      else if (m_ff < L2)   ls = 5'd2;
      else                  ls = 5'd1;
   end

   // datapath helpers
   always_comb begin
      sq_u     = u_ff[cnt_ff[1:0]][U_BITS-1:0];
      rt_sum   = root_ff + bit_ff;
      rt_ge    = ROOT_BITS'(srem_ff) >= rt_sum;
      num_full = (NUM_BITS'(u_ff[k_ff][U_BITS-1:0]) << AXIS_FRAC_BITS)
               + NUM_BITS'(n_ff >> 1);
      dv_t     = {drem_ff, num_ff[QUO_BITS-1]};
      dv_ge    = dv_t >= {1'b0, n_ff};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      u_in     = u_ff;
      m_in     = m_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      q_in     = q_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      n_in     = n_ff;
      drem_in  = drem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      unit_in  = unit_ff;
      ok_in    = ok_ff;
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  u_in[i]    = mag_v[i];
                  neg_in[i]  = vec[i][ACC_BITS-1];
                  unit_in[i] = '0;
               end
               m_in     = m_start;
               ok_in    = (m_start != '0);
               state_in = (m_start != '0) ? N_SHIFT : N_DONE;
            end
         end
         N_SHIFT: begin
            if (m_ff >= HI_LIM) begin
               m_in = m_ff >> rs;
               for (int i = 0; i < 3; i++) u_in[i] = u_ff[i] >> rs;
            end else if (m_ff < LO_LIM) begin
               m_in = m_ff << ls;
               for (int i = 0; i < 3; i++) u_in[i] = u_ff[i] << ls;
            end else begin
               state_in = N_SQ;
               cnt_in   = '0;
               q_in     = '0;
            end
         end
         N_SQ: begin
            // square one component per cycle, add each square into the sum in the next cycle
            if (cnt_ff != CNT_BITS'(SQ_LAST))
               prod_in = (2*U_BITS)'(sq_u) * (2*U_BITS)'(sq_u);
            if (cnt_ff != '0)
               q_in = q_ff + SQ_BITS'(prod_ff);
            if (cnt_ff == CNT_BITS'(SQ_LAST)) begin
               state_in = N_ROOT;
               srem_in  = q_ff + SQ_BITS'(prod_ff);
               root_in  = '0;
               bit_in   = ROOT_BITS'(1) << (ROOT_BITS - 1);
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         N_ROOT: begin
            // one result bit per cycle
            if (rt_ge) begin
               srem_in = srem_ff - rt_sum[SQ_BITS-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(ROOT_STEPS - 1)) begin
               state_in = N_DLOAD;
               n_in     = root_in[N_BITS-1:0];
               k_in     = '0;
            end
         end
         N_DLOAD: begin
            // rounded numerator, high part is already below the divisor
            drem_in  = N_BITS'(num_full[NUM_BITS-1:QUO_BITS]);
            num_in   = num_full[QUO_BITS-1:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = N_DRUN;
         end
         N_DRUN: begin
            // restoring division, one quotient bit per cycle
            drem_in = dv_ge ? N_BITS'(dv_t - {1'b0, n_ff}) : N_BITS'(dv_t);
            quo_in  = {quo_ff[QUO_BITS-2:0], dv_ge};
            num_in  = num_ff << 1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(QUO_BITS - 1)) begin
               unit_in[k_ff] = axis_from_mag(quo_in[QUO_BITS-1], quo_in, neg_ff[k_ff]);
               if (k_ff == 2'd2) begin
                  state_in = N_DONE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = N_DLOAD;
               end
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      m_ff    <= m_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      q_ff    <= q_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      n_ff    <= n_in;
      drem_ff <= drem_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      unit_ff <= unit_in;
      ok_ff   <= ok_in;
   end

   assign unit      = unit_ff;
   assign stat.done = (state_ff == N_DONE);
   assign stat.ok   = ok_ff;

endmodule

// ===== hw/rtl/tpf_front.sv =====
// Front end: point differences, translation clamp and the item queue.
`include "three_point_frame_from_plane_unit_assert.svh"
module tpf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  tpf_pkg::coord_type req_origin_x,
   input  tpf_pkg::coord_type req_origin_y,
   input  tpf_pkg::coord_type req_origin_z,
   input  tpf_pkg::coord_type req_xpoint_x,
   input  tpf_pkg::coord_type req_xpoint_y,
   input  tpf_pkg::coord_type req_xpoint_z,
   input  tpf_pkg::coord_type req_plane_x,
   input  tpf_pkg::coord_type req_plane_y,
   input  tpf_pkg::coord_type req_plane_z,
   output logic               deq_valid,
   input  logic               deq_pop,
   output tpf_pkg::item_type  deq_item
);
   import tpf_pkg::*;

   localparam int SAT_BITS = (COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS;
   localparam out_type OUT_MAXV = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam out_type OUT_MINV = {1'b1, {(OUT_BITS-1){1'b0}}};

   // clamp the origin into the result field range
   function automatic out_type sat_out(input coord_type v);
      logic signed [SAT_BITS-1:0] w;
      w = SAT_BITS'(v);
      if (w > SAT_BITS'(OUT_MAXV)) return OUT_MAXV;
      if (w < SAT_BITS'(OUT_MINV)) return OUT_MINV;
      return out_type'(w);
   endfunction

   item_type               mem_ff [QDEPTH];
   item_type               item_new;
   logic [QPTR_BITS-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                   push_ok, pop_ok;

   // classify: build the queued item
   always_comb begin
      item_new.a0 = DIFF_BITS'(req_xpoint_x) - DIFF_BITS'(req_origin_x);
      item_new.a1 = DIFF_BITS'(req_xpoint_y) - DIFF_BITS'(req_origin_y);
      item_new.a2 = DIFF_BITS'(req_xpoint_z) - DIFF_BITS'(req_origin_z);
      item_new.b0 = shr_mag(DIFF_BITS'(req_plane_x) - DIFF_BITS'(req_origin_x));
      item_new.b1 = shr_mag(DIFF_BITS'(req_plane_y) - DIFF_BITS'(req_origin_y));
      item_new.b2 = shr_mag(DIFF_BITS'(req_plane_z) - DIFF_BITS'(req_origin_z));
      item_new.t0 = sat_out(req_origin_x);
      item_new.t1 = sat_out(req_origin_y);
      item_new.t2 = sat_out(req_origin_z);
   end

   // queue pointers
   assign req_full  = (cnt_ff == QCNT_BITS'(QDEPTH));
   assign deq_valid = (cnt_ff != '0);
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = deq_pop && deq_valid;
   assign deq_item  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push_ok ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop_ok ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push_ok && !pop_ok) cnt_in = cnt_ff + 1'b1;
      if (!push_ok && pop_ok) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ff] <= item_new;
   end

   `TPF_ASSERT_IMP(a_q_bound, clock, reset, 1'b1, cnt_ff <= QCNT_BITS'(QDEPTH))
   `TPF_ASSERT_IMP(a_q_no_underflow, clock, reset, deq_pop, cnt_ff != '0)
   `TPF_ASSERT_NXT(a_q_fill, clock, reset, push_ok && !pop_ok, cnt_ff == $past(cnt_ff) + 1'b1)

endmodule

// ===== hw/rtl/tpf_back.sv =====
// Back end: X and Z axes through the normalizer, Y axis, result sequencing.
`include "three_point_frame_from_plane_unit_assert.svh"
module tpf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  tpf_pkg::item_type     q_item,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [1:0]            rsp_axis_sel,
   output tpf_pkg::out_type      rsp_comp_x,
   output tpf_pkg::out_type      rsp_comp_y,
   output tpf_pkg::out_type      rsp_comp_z,
   output logic                  rsp_degenerate,
   output logic                  rsp_last
);
   import tpf_pkg::*;

   typedef enum logic [6:0] {
      B_IDLE = 7'b0000001,
      B_NA   = 7'b0000010,
      B_XP   = 7'b0000100,
      B_NC   = 7'b0001000,
      B_YP   = 7'b0010000,
      B_YF   = 7'b0100000,
      B_OUT  = 7'b1000000
   } back_state_type;

   localparam int TERMS = 6;

   // Y axis: product difference shifted right by F, rounded, saturated
   function automatic axis_type ay_round(input acc_type v);
      logic [ACC_BITS-1:0] m;
      logic [ACC_BITS-1:0] r;
      m = v[ACC_BITS-1] ? (~v + 1'b1) : v;
      r = (m + (ACC_BITS'(1) << (AXIS_FRAC_BITS - 1))) >> AXIS_FRAC_BITS;
      return axis_from_mag(r >= (ACC_BITS'(1) << (AXIS_BITS - 1)),
                           r[AXIS_BITS-1:0], v[ACC_BITS-1]);
   endfunction

   back_state_type state_ff, state_in;
   diff_type       a_ff [3], a_in [3];
   xop_type        b_ff [3], b_in [3];
   out_type        tr_ff [3], tr_in [3];
   acc_type        acc_ff [3], acc_in [3];
   axis_type       ax_ff [3], ax_in [3], az_ff [3], az_in [3], ay_ff [3], ay_in [3];
   logic           ok_ff, ok_in;
   logic signed [2*MUL_BITS-1:0] prod_ff, prod_in;
   logic [2:0]     term_ff, term_in;
   axis_sel_type   sel_ff, sel_in;
   logic           start_ff, start_in;

   xop_type        a_sh [3];
   logic [1:0]     op_i, op_j;
   logic signed [MUL_BITS-1:0] op_a, op_b;
   logic [2:0]     term_j;
   logic [1:0]     acc_idx;
   acc_type        nvec [3];
   axis_type       nunit [3];
   norm_stat_type  nstat;

   tpf_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .vec   (nvec),
      .unit  (nunit),
      .stat  (nstat)
   );

   // normalizer input: X difference first, then the cross product
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_sh[i] = shr_mag(a_ff[i]);
         nvec[i] = (state_ff == B_NA) ? ACC_BITS'(a_ff[i]) : acc_ff[i];
      end
   end

   // cross product term order, shared by both products
   always_comb begin
      case (term_ff)
         3'd0: begin op_i = 2'd1; op_j = 2'd2; end
         3'd1: begin op_i = 2'd2; op_j = 2'd1; end
         3'd2: begin op_i = 2'd2; op_j = 2'd0; end
         3'd3: begin op_i = 2'd0; op_j = 2'd2; end
         3'd4: begin op_i = 2'd0; op_j = 2'd1; end
         3'd5: begin op_i = 2'd1; op_j = 2'd0; end
         default: begin op_i = 2'd0; op_j = 2'd0; end
      endcase
      if (state_ff == B_YP) begin
         op_a = MUL_BITS'(az_ff[op_i]);
         op_b = MUL_BITS'(ax_ff[op_j]);
      end else begin
         op_a = MUL_BITS'(a_sh[op_i]);
         op_b = MUL_BITS'(b_ff[op_j]);
      end
      term_j  = term_ff - 1'b1;
      acc_idx = term_j[2:1];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      tr_in    = tr_ff;
      acc_in   = acc_ff;
      ax_in    = ax_ff;
      az_in    = az_ff;
      ay_in    = ay_ff;
      ok_in    = ok_ff;
      prod_in  = (2*MUL_BITS)'(op_a) * (2*MUL_BITS)'(op_b);
      term_in  = term_ff;
      sel_in   = sel_ff;
      start_in = 1'b0;
      q_pop    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               a_in[0]  = q_item.a0;
               a_in[1]  = q_item.a1;
               a_in[2]  = q_item.a2;
               b_in[0]  = q_item.b0;
               b_in[1]  = q_item.b1;
               b_in[2]  = q_item.b2;
               tr_in[0] = q_item.t0;
               tr_in[1] = q_item.t1;
               tr_in[2] = q_item.t2;
               start_in = 1'b1;
               state_in = B_NA;
            end
         end
         B_NA: begin
            if (nstat.done) begin
               ax_in = nunit;
               ok_in = nstat.ok;
               term_in = '0;
               if (nstat.ok) begin
                  state_in = B_XP;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     ax_in[i] = '0;
                     az_in[i] = '0;
                     ay_in[i] = '0;
                  end
                  sel_in   = AXIS_X;
                  state_in = B_OUT;
               end
            end
         end
         B_XP, B_YP: begin
            // one product per cycle, added into its sum in the next cycle
            if (term_ff != '0)
               acc_in[acc_idx] = term_j[0] ? acc_ff[acc_idx] - ACC_BITS'(prod_ff)
                                           : ACC_BITS'(prod_ff);
            term_in = term_ff + 1'b1;
            if (term_ff == 3'(TERMS)) begin
               term_in = '0;
               if (state_ff == B_XP) begin
                  start_in = 1'b1;
                  state_in = B_NC;
               end else begin
                  state_in = B_YF;
               end
            end
         end
         B_NC: begin
            if (nstat.done) begin
               az_in = nunit;
               ok_in = nstat.ok;
               if (nstat.ok) begin
                  state_in = B_YP;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     ax_in[i] = '0;
                     az_in[i] = '0;
                     ay_in[i] = '0;
                  end
                  sel_in   = AXIS_X;
                  state_in = B_OUT;
               end
            end
         end
         B_YF: begin
            for (int i = 0; i < 3; i++) ay_in[i] = ay_round(acc_ff[i]);
            sel_in   = AXIS_X;
            state_in = B_OUT;
         end
         B_OUT: begin
            if (rsp_pop) begin
               if (sel_ff == AXIS_T) begin
                  state_in = B_IDLE;
               end else begin
                  sel_in = axis_sel_type'(sel_ff + 2'd1);
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      tr_ff   <= tr_in;
      acc_ff  <= acc_in;
      ax_ff   <= ax_in;
      az_ff   <= az_in;
      ay_ff   <= ay_in;
      ok_ff   <= ok_in;
      prod_ff <= prod_in;
      term_ff <= term_in;
      sel_ff  <= sel_in;
   end

   // result ports
   always_comb begin
      case (sel_ff)
         AXIS_X: begin
            rsp_comp_x = OUT_BITS'(ax_ff[0]);
            rsp_comp_y = OUT_BITS'(ax_ff[1]);
            rsp_comp_z = OUT_BITS'(ax_ff[2]);
         end
         AXIS_Z: begin
            rsp_comp_x = OUT_BITS'(az_ff[0]);
            rsp_comp_y = OUT_BITS'(az_ff[1]);
            rsp_comp_z = OUT_BITS'(az_ff[2]);
         end
         AXIS_Y: begin
            rsp_comp_x = OUT_BITS'(ay_ff[0]);
            rsp_comp_y = OUT_BITS'(ay_ff[1]);
            rsp_comp_z = OUT_BITS'(ay_ff[2]);
         end
         default: begin
            rsp_comp_x = tr_ff[0];
            rsp_comp_y = tr_ff[1];
            rsp_comp_z = tr_ff[2];
         end
      endcase
   end

   assign rsp_empty      = (state_ff != B_OUT);
   assign rsp_axis_sel   = sel_ff;
   assign rsp_degenerate = !ok_ff;
   assign rsp_last       = (sel_ff == AXIS_T);

   `TPF_ASSERT_IMP(a_degen_zero, clock, reset,
                   !rsp_empty && !ok_ff && sel_ff != AXIS_T,
                   rsp_comp_x == '0 && rsp_comp_y == '0 && rsp_comp_z == '0)
   `TPF_ASSERT_NXT(a_run_end, clock, reset,
                   !rsp_empty && rsp_pop && sel_ff == AXIS_T, state_ff == B_IDLE)
   `TPF_ASSERT_IMP(a_pop_idle, clock, reset, q_pop, state_ff == B_IDLE && q_valid)

endmodule
